FILE: rtl/gfe_pkg.sv
package gfe_pkg;

  localparam int TRIG_FRAC_BITS = 30;
  localparam int QW = TRIG_FRAC_BITS + 4;          // cos, sin, Newton terms
  localparam int ZW = 42;                          // CORDIC angle, 1e-10 deg
  localparam int IW = $clog2(TRIG_FRAC_BITS);      // CORDIC step counter
  localparam int RW = 43;                          // radii in Q8 mm

  localparam longint GAIN_Q62 = 64'sd2800459870029452960;
  localparam longint E2_Q62 = 64'sd30872378602570499;
  localparam longint RADPU_Q91 = 64'sd4321225925559515655;
  localparam longint SEMI_MAJOR_MM = 64'sd6378137000;
  localparam longint DEG_PER_RAD_E10 = 64'sd572957795131;
  localparam longint QUARTER_E7 = 64'sd900000000;

  localparam longint ONE = 64'sd1 <<< TRIG_FRAC_BITS;
  localparam longint THREE_ONE = 3 * ONE;
  localparam longint X0 = (GAIN_Q62 + (64'sd1 <<< (61 - TRIG_FRAC_BITS)))
                          >>> (62 - TRIG_FRAC_BITS);
  localparam longint E2Q = (E2_Q62 + (64'sd1 <<< (61 - TRIG_FRAC_BITS)))
                           >>> (62 - TRIG_FRAC_BITS);
  localparam longint ONE_M_E2 = ONE - E2Q;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [6:0]         sh;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } mul_rsp_t;

  // CORDIC arctangent of 2^-k in 1e-10 degree
  function automatic logic [39:0] atan_step(input int unsigned k);
    longint v;
    case (k)
      0:  v = 64'sd450000000000;
      1:  v = 64'sd265650511771;
      2:  v = 64'sd140362434679;
      3:  v = 64'sd71250163489;
      4:  v = 64'sd35763343750;
      5:  v = 64'sd17899106082;
      6:  v = 64'sd8951737102;
      7:  v = 64'sd4476141709;
      8:  v = 64'sd2238105004;
      9:  v = 64'sd1119056771;
      10: v = 64'sd559528919;
      11: v = 64'sd279764526;
      12: v = 64'sd139882271;
      13: v = 64'sd69941137;
      default: v = (DEG_PER_RAD_E10 + (64'sd1 <<< (k - 1))) >>> k;
    endcase
    return 40'(v);
  endfunction

  // clamp to a signed range of w bits
  function automatic logic signed [63:0] sat_w(input logic signed [63:0] v, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

endpackage

FILE: rtl/gnss_fix_to_local_enu.sv
// GNSS fix to local east/north/up offsets.
// Slave stream s_*: one fix per item. tuser carries the fix status; a
// negative status gives a result with fix_valid low and zero offsets.
// Master stream m_*: one result per accepted item, in order. tuser flags
// fix_valid and is_reference.
// Config channel cfg_*: registers preset_ref_lat (0), preset_ref_lon (1),
// preset_ref_alt (2), use_preset_ref (3). With use_preset_ref set, every
// write to registers 0 to 3 reloads the preset reference and recomputes
// its scales. A fix with a held reference takes two passes of the shared
// multiplier, then the output load; an invalid fix goes straight to the
// output load. The fix that latches the reference, and a config write that
// loads the preset (cfg_ready low meanwhile), run 30 CORDIC steps, then
// 21 sequenced multiplies for the Newton inverse square root, the radii
// and the scales.
// Both s_tready and cfg_ready are low while an item or a reload is at work.
// The result sits in an output register; a new item is taken while it
// waits, and the block holds its next result until m_tready frees it.
// Reset (rst, synchronous) drops the reference, clears the presets and
// empties the output register.
module gnss_fix_to_local_enu (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // latitude[30:0], longitude[62:31], altitude[90:63],
                                  // time_tag[122:91], zero pad
  input  logic [2:0]   s_tuser,   // fix_status[2:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // east_mm[36:0], north_mm[72:37], up_mm[100:73],
                                  // out_time_tag[132:101], zero pad
  output logic [1:0]   m_tuser,   // fix_valid[0], is_reference[1]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import gfe_pkg::*;

  localparam logic [2:0] CFG_LAT = 3'd0;
  localparam logic [2:0] CFG_LON = 3'd1;
  localparam logic [2:0] CFG_ALT = 3'd2;
  localparam logic [2:0] CFG_USE = 3'd3;

  // multiply sequence
  localparam logic [3:0] OP_YY  = 4'd0;   // sin^2
  localparam logic [3:0] OP_EW  = 4'd1;   // w = 1 - e2 sin^2
  localparam logic [3:0] OP_RR  = 4'd2;   // Newton: r^2
  localparam logic [3:0] OP_WT  = 4'd3;   // Newton: w r^2
  localparam logic [3:0] OP_RN  = 4'd4;   // Newton: r (3 - w r^2) / 2
  localparam logic [3:0] OP_NQ  = 4'd5;   // prime-vertical radius
  localparam logic [3:0] OP_P1  = 4'd6;
  localparam logic [3:0] OP_R2  = 4'd7;
  localparam logic [3:0] OP_MQ  = 4'd8;   // meridian radius
  localparam logic [3:0] OP_RC  = 4'd9;   // (N + h) cos
  localparam logic [3:0] OP_ES  = 4'd10;
  localparam logic [3:0] OP_NS  = 4'd11;
  localparam logic [3:0] OP_E   = 4'd12;
  localparam logic [3:0] OP_N   = 4'd13;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_CORD  = 6'b000100,
    S_MUL   = 6'b001000,
    S_MWAIT = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [3:0] op;
  logic [1:0] loop;
  logic [IW-1:0] i;

  logic signed [QW-1:0] x, y, w, r, t;
  logic signed [ZW-1:0] z;
  logic signed [RW-1:0] nq8, p1, mq8, rr;
  logic signed [39:0] es, ns;

  logic have_ref;
  logic signed [30:0] held_lat;
  logic signed [31:0] held_lon;
  logic signed [27:0] held_alt;
  logic signed [30:0] preset_lat;
  logic signed [31:0] preset_lon;
  logic signed [27:0] preset_alt;
  logic use_preset;
  logic emit;

  logic signed [31:0] d_lat;
  logic signed [32:0] d_lon;
  logic signed [36:0] res_e;
  logic signed [35:0] res_n;
  logic signed [27:0] res_u;
  logic res_valid, res_isref;
  logic [31:0] res_tag;

  mul_req_t req;
  mul_rsp_t rsp;

  logic signed [30:0] in_lat;
  logic signed [31:0] in_lon;
  logic signed [27:0] in_alt;
  logic signed [28:0] d_alt;
  logic signed [30:0] plat_n;
  logic signed [31:0] plon_n;
  logic signed [27:0] palt_n;
  logic use_n;
  logic signed [30:0] lat_c;
  logic signed [63:0] alt256;
  logic cfg_acc, in_acc;

  gfe_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign cfg_ready = (state == S_IDLE);
  assign s_tready = (state == S_IDLE) && !cfg_valid;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign in_acc = s_tvalid && s_tready;

  assign in_lat = s_tdata[30:0];
  assign in_lon = s_tdata[62:31];
  assign in_alt = s_tdata[90:63];
  assign d_alt = 29'(in_alt) - 29'(held_alt);
  assign alt256 = {{28{held_alt[27]}}, held_alt, 8'd0};

  // clamp the reference latitude to the poles for the trig only
  always_comb begin
    if (64'(held_lat) > QUARTER_E7) lat_c = 31'(QUARTER_E7);
    else if (64'(held_lat) < -QUARTER_E7) lat_c = 31'(-QUARTER_E7);
    else lat_c = held_lat;
  end

  // presets as they stand after this write
  always_comb begin
    plat_n = preset_lat;
    plon_n = preset_lon;
    palt_n = preset_alt;
    use_n = use_preset;
    case (cfg_index)
      CFG_LAT: plat_n = cfg_data[30:0];
      CFG_LON: plon_n = cfg_data;
      CFG_ALT: palt_n = cfg_data[27:0];
      CFG_USE: use_n = cfg_data[0];
      default: ;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    req.start = (state == S_MUL);
    req.a = 64'sd0;
    req.b = 64'sd0;
    req.sh = 7'(TRIG_FRAC_BITS);
    case (op)
      OP_YY: begin req.a = 64'(y); req.b = 64'(y); end
      OP_EW: begin req.a = E2Q; req.b = 64'(t); end
      OP_RR, OP_R2: begin req.a = 64'(r); req.b = 64'(r); end
      OP_WT: begin req.a = 64'(w); req.b = 64'(t); end
      OP_RN: begin
        req.a = 64'(r);
        req.b = THREE_ONE - 64'(t);
        req.sh = 7'(TRIG_FRAC_BITS + 1);
      end
      OP_NQ: begin
        req.a = SEMI_MAJOR_MM;
        req.b = 64'(r);
        req.sh = 7'(TRIG_FRAC_BITS - 8);
      end
      OP_P1: begin req.a = 64'(nq8); req.b = ONE_M_E2; end
      OP_MQ: begin req.a = 64'(p1); req.b = 64'(t); end
      OP_RC: begin req.a = 64'(nq8) + alt256; req.b = 64'(x); end
      OP_ES: begin req.a = 64'(rr); req.b = RADPU_Q91; req.sh = 7'd64; end
      OP_NS: begin req.a = 64'(mq8) + alt256; req.b = RADPU_Q91; req.sh = 7'd64; end
      OP_E: begin req.a = 64'(es); req.b = 64'(d_lon); req.sh = 7'd35; end
      OP_N: begin req.a = 64'(ns); req.b = 64'(d_lat); req.sh = 7'd35; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      have_ref <= 1'b0;
      preset_lat <= '0;
      preset_lon <= '0;
      preset_alt <= '0;
      use_preset <= 1'b0;
      held_lat <= '0;
      held_lon <= '0;
      held_alt <= '0;
      es <= '0;
      ns <= '0;
      m_tvalid <= 1'b0;
      op <= OP_YY;
      loop <= 2'd0;
      i <= '0;
      emit <= 1'b0;
    end else begin
      // free the output register once taken, unless a new result refills it
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            preset_lat <= plat_n;
            preset_lon <= plon_n;
            preset_alt <= palt_n;
            use_preset <= use_n;
            emit <= 1'b0;
            if (cfg_index == CFG_USE && !cfg_data[0]) begin
              have_ref <= 1'b0;
            end else if (cfg_index <= CFG_USE && use_n) begin
              // load the preset reference and rebuild its scales
              held_lat <= plat_n;
              held_lon <= plon_n;
              held_alt <= palt_n;
              have_ref <= 1'b1;
              state <= S_INIT;
            end
          end else if (in_acc) begin
            res_tag <= s_tdata[122:91];
            emit <= 1'b1;
            res_e <= '0;
            res_n <= '0;
            res_u <= (!s_tuser[2] && have_ref) ? 28'(sat_w(64'(d_alt), 28)) : '0;
            res_isref <= !s_tuser[2] && !have_ref;
            if (s_tuser[2]) begin
              res_valid <= 1'b0;
              state <= S_OUT;
            end else if (have_ref) begin
              res_valid <= 1'b1;
              d_lat <= 32'(in_lat) - 32'(held_lat);
              d_lon <= 33'(in_lon) - 33'(held_lon);
              op <= OP_E;
              state <= S_MUL;
            end else begin
              // first valid fix becomes the reference
              res_valid <= 1'b1;
              held_lat <= in_lat;
              held_lon <= in_lon;
              held_alt <= in_alt;
              have_ref <= 1'b1;
              state <= S_INIT;
            end
          end
        end

        S_INIT: begin
          x <= QW'(X0);
          y <= '0;
          z <= ZW'(lat_c) * ZW'(1000);
          r <= QW'(ONE);
          i <= '0;
          loop <= 2'd0;
          state <= S_CORD;
        end

        S_CORD: begin
          // rotate toward zero angle; x ends as cos, y as sin
          if (!z[ZW-1]) begin
            x <= x - (y >>> i);
            y <= y + (x >>> i);
            z <= z - ZW'(atan_step(32'(i)));
          end else begin
            x <= x + (y >>> i);
            y <= y - (x >>> i);
            z <= z + ZW'(atan_step(32'(i)));
          end
          if (i == IW'(TRIG_FRAC_BITS - 1)) begin
            op <= OP_YY;
            state <= S_MUL;
          end else begin
            i <= i + IW'(1);
          end
        end

        S_MUL: state <= S_MWAIT;

        S_MWAIT: begin
          if (rsp.done) begin
            // advance the sequence; loop back for the next Newton step
            op <= (op == OP_RN && loop != 2'd3) ? OP_RR : op + 4'd1;
            if (op == OP_NS) state <= emit ? S_OUT : S_IDLE;
            else if (op == OP_N) state <= S_OUT;
            else if (op > OP_N) state <= S_IDLE;
            else state <= S_MUL;
            case (op)
              OP_YY, OP_RR, OP_WT, OP_R2: t <= QW'(rsp.res);
              OP_EW: w <= QW'(ONE - rsp.res);
              OP_RN: begin
                r <= QW'(rsp.res);
                if (loop != 2'd3) loop <= loop + 2'd1;
              end
              OP_NQ: nq8 <= RW'(rsp.res);
              OP_P1: p1 <= RW'(rsp.res);
              OP_MQ: mq8 <= RW'(rsp.res);
              OP_RC: rr <= RW'(rsp.res);
              OP_ES: es <= 40'(sat_w(rsp.res, 40));
              OP_NS: ns <= 40'(sat_w(rsp.res, 40));
              OP_E: res_e <= 37'(sat_w(rsp.res, 37));
              OP_N: res_n <= 36'(sat_w(rsp.res, 36));
              default: ;
            endcase
          end
        end

        S_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata <= {3'd0, res_tag, res_u, res_n, res_e};
            m_tuser <= {res_isref, res_valid};
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_pair: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> cfg_ready)
    else $error("item ready while config busy");
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after an accepted item");
  a_ref_drop: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == CFG_USE && !cfg_data[0]) |=> !have_ref)
    else $error("reference kept after preset disable");
  a_ref_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tuser[0])
    else $error("reference result marked invalid");
`endif

endmodule

FILE: rtl/gfe_mul.sv
module gfe_mul (
  input  logic              clk,
  input  logic              rst,
  input  gfe_pkg::mul_req_t req,
  output gfe_pkg::mul_rsp_t rsp
);
  import gfe_pkg::*;

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic [6:0]   sh;
  logic [127:0] acc;
  logic [2:0]   ph;
  logic         busy;

  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  prod;
  logic [127:0] part;
  logic [127:0] rnd;
  logic [127:0] sum;
  logic [127:0] q;
  logic [63:0]  mag;

  // one 32x32 partial product per phase
  always_comb begin
    pa = ph[0] ? ua[63:32] : ua[31:0];
    pb = ph[1] ? ub[63:32] : ub[31:0];
    prod = pa * pb;
    case (ph[1:0])
      2'd0:    part = {64'd0, prod};
      2'd3:    part = {prod, 64'd0};
      default: part = {32'd0, prod, 32'd0};
    endcase
  end

  // round half away from zero, shift, clamp to the largest positive value
  always_comb begin
    rnd = (sh == 7'd0) ? 128'd0 : (128'd1 << (sh - 7'd1));
    sum = acc + rnd;
    q = sum >> sh;
    mag = (|q[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
    rsp.res = neg ? -$signed(mag) : $signed(mag);
    rsp.done = busy && (ph == 3'd4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph <= 3'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      ph <= 3'd0;
      acc <= 128'd0;
      ua <= req.a[63] ? 64'(-req.a) : 64'(req.a);
      ub <= req.b[63] ? 64'(-req.b) : 64'(req.b);
      neg <= req.a[63] != req.b[63];
      sh <= req.sh;
    end else if (busy) begin
      if (ph != 3'd4) begin
        acc <= acc + part;
        ph <= ph + 3'd1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/tb_gnss_fix_to_local_enu.sv
module tb_gnss_fix_to_local_enu;
  import gfe_pkg::*;

  // Config register indexes, in the block's register order.
  localparam logic [2:0] REG_REF_LAT = 3'd0;
  localparam logic [2:0] REG_REF_LON = 3'd1;
  localparam logic [2:0] REG_REF_ALT = 3'd2;
  localparam logic [2:0] REG_USE_PRESET = 3'd3;
  localparam logic [2:0] REG_UNUSED = 3'd5;

  // Fix status codes; anything with the sign bit set means no fix.
  localparam logic [2:0] ST_NO_FIX = 3'b111;
  localparam logic [2:0] ST_NO_FIX_MIN = 3'b100;
  localparam logic [2:0] ST_FIX = 3'd0;
  localparam logic [2:0] ST_AUGMENTED = 3'd1;
  localparam logic [2:0] ST_GBAS = 3'd2;
  localparam logic [2:0] ST_SPARE = 3'd3;

  // Cycles to let pass before a config write, longer than a reference reload.
  localparam int SETTLE_CYCLES = 250;

  typedef struct {
    logic [36:0] east;
    logic [35:0] north;
    logic [27:0] up;
    logic        valid;
    logic        is_ref;
    logic [31:0] tag;
  } enu_t;

  // Scoreboard: keeps its own copy of the reference and scales, turns each
  // accepted fix into an expected ENU result and checks results in order.
  class enu_scoreboard;
    longint preset_lat, preset_lon, preset_alt;
    bit     use_preset;
    bit     have_ref;
    longint ref_lat, ref_lon, ref_alt;
    longint east_scale, north_scale;
    enu_t   pending_enu[$];
    int     errors, results, fixes, invalids, latches;

    function void clear();
      preset_lat = 0; preset_lon = 0; preset_alt = 0;
      use_preset = 0; have_ref = 0;
      ref_lat = 0; ref_lon = 0; ref_alt = 0;
      east_scale = 0; north_scale = 0;
    endfunction

    // round(a*b / 2^s) half away from zero, magnitude capped at 2^63-1
    function longint mul_round(longint a, longint b, int s);
      logic [127:0] ua, ub, p;
      logic         neg;
      neg = (a < 0) != (b < 0);
      ua = {64'd0, (a < 0) ? 64'(-a) : 64'(a)};
      ub = {64'd0, (b < 0) ? 64'(-b) : 64'(b)};
      p = ua * ub;
      if (s > 0) p = p + (128'd1 << (s - 1));
      p = p >> s;
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function longint clamp_w(longint v, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
    endfunction

    // arctan(2^-i) in 1e-10 degree
    function longint arc_step(int i);
      longint tbl[14];
      tbl = '{64'sd450000000000, 64'sd265650511771, 64'sd140362434679,
              64'sd71250163489, 64'sd35763343750, 64'sd17899106082,
              64'sd8951737102, 64'sd4476141709, 64'sd2238105004,
              64'sd1119056771, 64'sd559528919, 64'sd279764526,
              64'sd139882271, 64'sd69941137};
      if (i < 14) return tbl[i];
      return (DEG_PER_RAD_E10 + (64'sd1 <<< (i - 1))) >>> i;
    endfunction

    // Radii and cos(ref lat) by CORDIC and Newton, folded into two scales.
    function void derive_scales();
      int     f;
      longint one, lat, x, y, z, dx, dy, e2, w, r, t, nq8, mq8, rr;
      f = TRIG_FRAC_BITS;
      one = 64'sd1 <<< f;
      lat = ref_lat;
      if (lat > QUARTER_E7) lat = QUARTER_E7;
      if (lat < -QUARTER_E7) lat = -QUARTER_E7;
      x = (GAIN_Q62 + (64'sd1 <<< (61 - f))) >>> (62 - f);
      y = 0;
      z = lat * 1000;
      for (int i = 0; i < f; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arc_step(i);
        end else begin
          x += dx; y -= dy; z += arc_step(i);
        end
      end
      e2 = (E2_Q62 + (64'sd1 <<< (61 - f))) >>> (62 - f);
      w = one - mul_round(e2, mul_round(y, y, f), f);
      r = one;
      for (int i = 0; i < 4; i++) begin
        t = mul_round(w, mul_round(r, r, f), f);
        r = mul_round(r, 3 * one - t, f + 1);
      end
      nq8 = mul_round(SEMI_MAJOR_MM, r, f - 8);
      mq8 = mul_round(mul_round(nq8, one - e2, f), mul_round(r, r, f), f);
      rr = mul_round(nq8 + ref_alt * 256, x, f);
      east_scale = clamp_w(mul_round(rr, RADPU_Q91, 64), 40);
      north_scale = clamp_w(mul_round(mq8 + ref_alt * 256, RADPU_Q91, 64), 40);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_REF_LAT:    preset_lat = $signed(data[30:0]);
        REG_REF_LON:    preset_lon = $signed(data[31:0]);
        REG_REF_ALT:    preset_alt = $signed(data[27:0]);
        REG_USE_PRESET: begin
          use_preset = data[0];
          if (!use_preset) have_ref = 0;
        end
        default: return;
      endcase
      if (use_preset) begin
        ref_lat = preset_lat; ref_lon = preset_lon; ref_alt = preset_alt;
        derive_scales();
        have_ref = 1;
      end
    endfunction

    function void note_fix(logic [30:0] lat_in, logic [31:0] lon_in, logic [27:0] alt_in,
                           logic [2:0] status, logic [31:0] tag);
      enu_t   x;
      longint lat, lon, alt;
      lat = $signed(lat_in);
      lon = $signed(lon_in);
      alt = $signed(alt_in);
      x = '{east: '0, north: '0, up: '0, valid: 1'b0, is_ref: 1'b0, tag: tag};
      fixes++;
      if (!status[2]) begin
        x.valid = 1'b1;
        if (have_ref) begin
          x.east = 37'(clamp_w(mul_round(east_scale, lon - ref_lon, 35), 37));
          x.north = 36'(clamp_w(mul_round(north_scale, lat - ref_lat, 35), 36));
          x.up = 28'(clamp_w(alt - ref_alt, 28));
        end else begin
          ref_lat = lat; ref_lon = lon; ref_alt = alt;
          derive_scales();
          have_ref = 1;
          x.is_ref = 1'b1;
          latches++;
        end
      end else begin
        invalids++;
      end
      pending_enu.push_back(x);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task check_result(logic [135:0] data, logic [1:0] user);
      enu_t x;
      results++;
      if (pending_enu.size() == 0) begin
        report("unexpected result", 64'(data[36:0]), 64'd0);
        return;
      end
      x = pending_enu.pop_front();
      if (data[36:0] != x.east) report("east_mm", 64'(data[36:0]), 64'(x.east));
      if (data[72:37] != x.north) report("north_mm", 64'(data[72:37]), 64'(x.north));
      if (data[100:73] != x.up) report("up_mm", 64'(data[100:73]), 64'(x.up));
      if (data[132:101] != x.tag) report("out_time_tag", 64'(data[132:101]), 64'(x.tag));
      if (user[0] != x.valid) report("fix_valid", 64'(user[0]), 64'(x.valid));
      if (user[1] != x.is_ref) report("is_reference", 64'(user[1]), 64'(x.is_ref));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  enu_scoreboard enu_sb = new();
  int burst_left = 0;
  int cfg_writes = 0;

  gnss_fix_to_local_enu i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: switch between always ready, coin flips and long stalls.
  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= int'($urandom_range(0, 2));
      stall_count <= int'($urandom_range(10, 80));
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Check every result taken off the master side.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) enu_sb.check_result(m_tdata, m_tuser);
  end

  // Offer one fix and hold it until taken, then maybe insert a gap.
  task send_fix(logic [30:0] lat, logic [31:0] lon, logic [27:0] alt,
                logic [2:0] status, logic [31:0] tag);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, tag, alt, lon, lat};
    s_tuser <= status;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    enu_sb.note_fix(lat, lon, alt, status, tag);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drain the block, then let it settle before touching its registers.
  task wait_idle();
    s_tvalid <= 1'b0;
    while (enu_sb.pending_enu.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_cfg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    enu_sb.write_reg(idx, data);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_lat();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'(longint'($urandom_range(32'd1800000000)) - 900000000);
  endfunction

  function automatic logic [31:0] rand_lon();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
  endfunction

  function automatic logic [31:0] rand_alt();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'(longint'($urandom_range(32'd101000000)) - 1000000);
  endfunction

  // Random fix: mostly close to the held reference, some anywhere, some raw.
  task send_random_fix();
    logic [30:0] lat;
    logic [31:0] lon;
    logic [27:0] alt;
    logic [2:0]  status;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 60 && enu_sb.have_ref) begin
      lat = 31'(enu_sb.ref_lat + $signed($urandom_range(0, 2000000)) - 1000000);
      lon = 32'(enu_sb.ref_lon + $signed($urandom_range(0, 2000000)) - 1000000);
      alt = 28'(enu_sb.ref_alt + $signed($urandom_range(0, 200000)) - 100000);
    end else begin
      lat = 31'(rand_lat());
      lon = rand_lon();
      alt = 28'(rand_alt());
    end
    status = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7))
                                         : 3'($urandom_range(0, 3));
    send_fix(lat, lon, alt, status, $urandom);
  endtask

  initial begin
    enu_sb.clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Latched reference: no fix first, then latch, then the field extremes.
    send_fix(31'd0, 32'd0, 28'd0, ST_NO_FIX, 32'd0);
    send_fix(31'd0, 32'd0, 28'd0, ST_NO_FIX_MIN, 32'hFFFF_FFFF);
    send_fix(31'd0, 32'd0, 28'd0, ST_FIX, 32'd1);
    send_fix(31'(900000000), 32'(1800000000), 28'(100000000), ST_AUGMENTED, 32'd2);
    send_fix(31'(-900000000), -32'(1800000000), -28'(1000000), ST_GBAS, 32'd3);
    send_fix(31'h3FFF_FFFF, 32'h7FFF_FFFF, 28'h7FF_FFFF, ST_SPARE, 32'h8000_0000);
    send_fix(31'h4000_0000, 32'h8000_0000, 28'h800_0000, ST_FIX, 32'h5A5A_A5A5);
    send_fix(31'd10, 32'd10, 28'd10, ST_NO_FIX, 32'd4);

    // Preset at the north pole and far corners, then latitude words with bit 31 set.
    wait_idle();
    write_cfg(REG_REF_LAT, 32'(900000000));
    write_cfg(REG_REF_LON, -32'(1800000000));
    write_cfg(REG_REF_ALT, 32'(100000000));
    write_cfg(REG_USE_PRESET, 32'd1);
    send_fix(31'(-900000000), 32'(1800000000), -28'(1000000), ST_FIX, 32'd5);
    send_fix(31'(899999999), -32'(1799999999), 28'd0, ST_GBAS, 32'd6);
    wait_idle();
    write_cfg(REG_REF_LAT, 32'h7FFF_FFFF);
    write_cfg(REG_REF_ALT, -32'(1000000));
    write_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    send_fix(31'd0, 32'd0, 28'd0, ST_FIX, 32'd7);
    send_fix(31'h4000_0000, 32'h7FFF_FFFF, 28'h7FF_FFFF, ST_AUGMENTED, 32'd8);
    wait_idle();
    write_cfg(REG_REF_LAT, 32'h8000_0000 | 32'(-900000000));
    send_fix(31'(900000000), 32'd0, 28'(100000000), ST_FIX, 32'd9);
    wait_idle();
    // Drop the preset: the next valid fix latches again.
    write_cfg(REG_USE_PRESET, 32'hFFFF_FFFE);
    send_fix(31'(451234567), -32'(1223456789), 28'(1500000), ST_FIX, 32'd10);
    send_fix(31'(451234568), -32'(1223456780), 28'(1499000), ST_FIX, 32'd11);

    // Random phases, each under a fresh register setting.
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      write_cfg(REG_REF_LAT, rand_lat());
      write_cfg(REG_REF_LON, rand_lon());
      write_cfg(REG_REF_ALT, rand_alt());
      write_cfg(REG_USE_PRESET, $urandom_range(0, 1) ? $urandom | 32'd1 : 32'd0);
      if ($urandom_range(0, 2) == 0) write_cfg(3'($urandom_range(4, 7)), $urandom);
      repeat (75) send_random_fix();
    end

    wait_idle();
    $display("fixes sent %0d (%0d without a fix, %0d latched as reference), results %0d",
             enu_sb.fixes, enu_sb.invalids, enu_sb.latches, enu_sb.results);
    $display("register writes %0d, mismatches %0d", cfg_writes, enu_sb.errors);
    if (enu_sb.errors == 0 && enu_sb.pending_enu.size() == 0) begin
      $display("[gnss_fix_to_local_enu] OK");
    end else begin
      $display("[gnss_fix_to_local_enu] ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #40_000_000;
    $display("[gnss_fix_to_local_enu] ERROR");
    $finish;
  end

endmodule
